// ===== src/brs_pkg.sv =====
// package for the brent root step engine
// q24.40 fixed point types, sequencer states, constants and saturating helpers; no dependencies
`default_nettype none
package brs_pkg;

  localparam int unsigned FRAC = 40;
  localparam logic signed [63:0] ONE_Q    = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0] HALF_Q   = 64'sh0000_0080_0000_0000;
  localparam logic signed [63:0] THREEQ_Q = 64'sh0000_00C0_0000_0000;
  localparam logic signed [63:0] S_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN    = 64'sh8000_0000_0000_0000;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [2:0]         lane;
    logic signed [63:0] x_lo;
    logic signed [63:0] x_hi;
    logic signed [63:0] f_lo;
    logic signed [63:0] f_new;
    logic [62:0]        tolerance;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         out_lane;
    logic signed [63:0] next_x;
    logic               done_res;
    logic [15:0]        passes;
  } out_beat_t;

  // shared arithmetic unit operations
  typedef enum logic [0:0] {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef struct packed {
    logic               start;
    op_t                op;
    logic signed [63:0] x;
    logic signed [63:0] y;
  } au_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_PREP, S_SWAP, S_TEST, S_IQ0,
    S_D1, S_D1W, S_D2, S_D2W, S_D3, S_D3W,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_M4, S_M4W, S_M5, S_M5W,
    S_M6, S_M6W,
    S_SIGN,
    S_L1, S_L1W, S_L2, S_L2W, S_L3, S_L3W, S_L4, S_L4W, S_L5, S_L5W,
    S_L6, S_L6W,
    S_CMP, S_QW, S_CLAMP, S_STORE, S_OUT
  } state_t;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    c = m[63] ? 64'(S_MAX) : m;
    from_mag = neg ? -$signed(c) : $signed(c);
  endfunction

  function automatic logic signed [63:0] s_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'(S_MAX)) s_sub = S_MAX;
    else if (d < 65'(S_MIN)) s_sub = S_MIN;
    else s_sub = d[63:0];
  endfunction

  function automatic logic signed [63:0] s_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] d;
    d = 65'(a) + 65'(b);
    if (d > 65'(S_MAX)) s_add = S_MAX;
    else if (d < 65'(S_MIN)) s_add = S_MIN;
    else s_add = d[63:0];
  endfunction

  function automatic logic signed [63:0] s_neg(input logic signed [63:0] x);
    s_neg = (x == S_MIN) ? S_MAX : -x;
  endfunction

  function automatic logic signed [63:0] s_abs(input logic signed [63:0] x);
    s_abs = from_mag(1'b0, mag(x));
  endfunction

endpackage
`default_nettype wire

// ===== src/brs_arith.sv =====
// shared iterative fixed point multiply and divide unit
// depends on brs_pkg; multiply 16x64 per cycle, divide one quotient bit per cycle
`default_nettype none
module brs_arith
  import brs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire au_req_t            req,
  output logic                    busy,
  output logic                    done,
  output logic signed [63:0]      result
);

  logic         run;
  op_t          op;
  logic         neg;
  logic         dz;
  logic         xsign;
  logic         nz;
  logic [63:0]  a_m;
  logic [63:0]  b_m;
  logic [127:0] acc;       // product accumulator or dividend shift register
  logic [64:0]  rem;
  logic [63:0]  quo;
  logic         over;
  logic [6:0]   cnt;

  logic [79:0]  part;
  logic [64:0]  rem_sh;
  logic [64:0]  rem_sub;
  logic [6:0]   bit_idx;

  assign busy = run;
  assign part = 80'(a_m[15:0]) * 80'(b_m);
  assign rem_sh  = {rem[63:0], acc[127]};
  assign rem_sub = rem_sh - 65'(b_m);
  assign bit_idx = 7'd127 - cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !run) begin
        run   <= 1'b1;
        op    <= req.op;
        neg   <= req.x[63] != req.y[63];
        xsign <= req.x[63];
        a_m   <= mag(req.x);
        b_m   <= mag(req.y);
        dz    <= (req.y == 64'sd0);
        nz    <= (req.x != 64'sd0);
        rem   <= '0;
        quo   <= '0;
        over  <= 1'b0;
        cnt   <= '0;
        acc   <= (req.op == OP_DIV) ? {mag(req.x), 64'd0} >> (64 - FRAC) : '0;
      end else if (run) begin
        if (op == OP_MUL) begin
          // one 16-bit slice of the multiplier per cycle
          acc <= acc + ({48'd0, part} << (cnt[1:0] * 16));
          a_m <= a_m >> 16;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd3) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end else if (dz) begin
          run    <= 1'b0;
          done   <= 1'b1;
        end else begin
          // restoring division, one quotient bit per cycle
          acc <= acc << 1;
          if (rem_sh >= 65'(b_m)) begin
            rem <= rem_sub;
            if (bit_idx >= 7'd63) over <= 1'b1;
            else quo[bit_idx[5:0]] <= 1'b1;
          end else begin
            rem <= rem_sh;
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (op == OP_MUL) begin
      if (acc[127:103] != '0) result = from_mag(neg, '1);
      else result = from_mag(neg, acc[103:40]);
    end else if (dz) begin
      result = nz ? from_mag(xsign, '1) : 64'sd0;
    end else begin
      result = from_mag(neg, over ? '1 : quo);
    end
  end

endmodule
`default_nettype wire

// ===== src/brent_root_step.sv =====
// brent root step engine, top level
// channel 'in' takes start or step beats, channel 'out' returns one beat per item
// every item on a live lane runs one bracketing pass: keep the bracket, swap to
// the best end, test convergence, then inverse quadratic, secant or bisection
// all values are signed q24.40; one shared multiply/divide unit (brs_arith)
// does every interpolation product and quotient under the sequencer below
// a step on a converged lane replays the stored root; a converging pass goes
// straight to the store and a bisection pass goes through the clamp; secant
// and inverse quadratic passes wait on the bit-serial divides (up to four per
// pass) and the multiplies (up to twelve per pass) of the shared unit
// in_ready is high only in idle with no result beat pending; one item at a time
// the result waits in the output register while out_ready is low; the next
// item is taken once that beat has been accepted
// reset clears lane_done and pass counts; lane point and value stores are
// undefined until a start beat writes them
// beats with lane not below LANES are dropped without result
`default_nettype none
module brent_root_step
  import brs_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  // per lane state
  logic signed [63:0] m_a  [LANES];
  logic signed [63:0] m_b  [LANES];
  logic signed [63:0] m_c  [LANES];
  logic signed [63:0] m_fa [LANES];
  logic signed [63:0] m_fc [LANES];
  logic [62:0]        m_tol[LANES];
  logic [LANES-1:0]   lane_done;
  logic [15:0]        pass_count [LANES];

  state_t state, state_next;

  // working registers of the pass
  in_beat_t           item;
  logic [LW-1:0]      k;
  logic signed [63:0] a, b, c, fa, fb, fc;
  logic signed [63:0] prev, tol_act, step, cb;
  logic signed [63:0] p, q, t1, t2, r1, r2, lim1;
  logic [15:0]        cnt;
  logic               converged;

  au_req_t            au_req;
  logic               au_busy, au_done;
  logic signed [63:0] au_res;

  brs_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (au_req),
    .busy   (au_busy),
    .done   (au_done),
    .result (au_res)
  );

  logic in_ok;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign in_ok = in_valid && in_ready && (32'(in_data.lane) < LANES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_ok) state_next = S_LOAD;
      S_LOAD:  begin
        if (item.func == FUNC_STEP && lane_done[k]) state_next = S_OUT;
        else state_next = S_PREP;
      end
      S_PREP:  state_next = S_SWAP;
      S_SWAP:  state_next = S_TEST;
      S_TEST:  begin
        if (mag(step) <= 64'(tol_act) || fb == 64'sd0) state_next = S_STORE;
        else if (mag(prev) >= 64'(tol_act) && mag(fa) > mag(fb)) state_next = S_IQ0;
        else state_next = S_CLAMP;
      end
      S_IQ0:   state_next = (a == c) ? S_D3 : S_D1;
      S_D1:    state_next = S_D1W;
      S_D1W:   if (au_done) state_next = S_D2;
      S_D2:    state_next = S_D2W;
      S_D2W:   if (au_done) state_next = S_D3;
      S_D3:    state_next = S_D3W;
      S_D3W:   if (au_done) state_next = S_M1;
      S_M1:    state_next = S_M1W;
      S_M1W:   if (au_done) state_next = (a == c) ? S_SIGN : S_M2;
      S_M2:    state_next = S_M2W;
      S_M2W:   if (au_done) state_next = S_M3;
      S_M3:    state_next = S_M3W;
      S_M3W:   if (au_done) state_next = S_M4;
      S_M4:    state_next = S_M4W;
      S_M4W:   if (au_done) state_next = S_M5;
      S_M5:    state_next = S_M5W;
      S_M5W:   if (au_done) state_next = S_M6;
      S_M6:    state_next = S_M6W;
      S_M6W:   if (au_done) state_next = S_SIGN;
      S_SIGN:  state_next = S_L1;
      S_L1:    state_next = S_L1W;
      S_L1W:   if (au_done) state_next = S_L2;
      S_L2:    state_next = S_L2W;
      S_L2W:   if (au_done) state_next = S_L3;
      S_L3:    state_next = S_L3W;
      S_L3W:   if (au_done) state_next = S_L4;
      S_L4:    state_next = S_L4W;
      S_L4W:   if (au_done) state_next = S_L5;
      S_L5:    state_next = S_L5W;
      S_L5W:   if (au_done) state_next = S_L6;
      S_L6:    state_next = S_L6W;
      S_L6W:   if (au_done) state_next = S_CMP;
      S_CMP:   state_next = (p < lim1 && p < s_abs(r2)) ? S_QW : S_CLAMP;
      S_QW:    if (au_done) state_next = S_CLAMP;
      S_CLAMP: state_next = S_STORE;
      S_STORE: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // requests to the shared unit
  always_comb begin
    au_req = '{start: 1'b0, op: OP_MUL, x: 64'sd0, y: 64'sd0};
    unique case (state)
      S_D1: au_req = '{1'b1, OP_DIV, fa, fc};
      S_D2: au_req = '{1'b1, OP_DIV, fb, fc};
      S_D3: au_req = '{1'b1, OP_DIV, fb, fa};
      S_M1: begin
        if (a == c) au_req = '{1'b1, OP_MUL, cb, t2};
        else au_req = '{1'b1, OP_MUL, cb, q};
      end
      S_M2: au_req = '{1'b1, OP_MUL, r1, s_sub(q, t1)};
      S_M3: au_req = '{1'b1, OP_MUL, s_sub(b, a), s_sub(t1, ONE_Q)};
      S_M4: au_req = '{1'b1, OP_MUL, t2, s_sub(r1, r2)};
      S_M5: au_req = '{1'b1, OP_MUL, s_sub(q, ONE_Q), s_sub(t1, ONE_Q)};
      S_M6: au_req = '{1'b1, OP_MUL, r1, s_sub(t2, ONE_Q)};
      S_L1: au_req = '{1'b1, OP_MUL, THREEQ_Q, cb};
      S_L2: au_req = '{1'b1, OP_MUL, r1, q};
      S_L3: au_req = '{1'b1, OP_MUL, tol_act, q};
      S_L4: au_req = '{1'b1, OP_MUL, HALF_Q, s_abs(r1)};
      S_L5: au_req = '{1'b1, OP_MUL, HALF_Q, prev};
      S_L6: au_req = '{1'b1, OP_MUL, r2, q};
      // the quotient p/q is started from the compare state
      S_CMP: if (p < lim1 && p < s_abs(r2)) au_req = '{1'b1, OP_DIV, p, q};
      default: au_req = '{start: 1'b0, op: OP_MUL, x: 64'sd0, y: 64'sd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lane_done <= '0;
      for (int i = 0; i < LANES; i++) pass_count[i] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ok) begin
          item <= in_data;
          k    <= LW'(in_data.lane);
        end
        S_LOAD: begin
          if (item.func == FUNC_START) begin
            converged <= 1'b0;
            a  <= item.x_lo;  b  <= item.x_hi;  c  <= item.x_lo;
            fa <= item.f_lo;  fb <= item.f_new; fc <= item.f_lo;
            tol_act <= 64'sd1 + 64'({1'b0, item.tolerance} >> 1);
            m_tol[k] <= item.tolerance;
            cnt <= 16'd1;
            lane_done[k] <= 1'b0;
          end else if (lane_done[k]) begin
            // converged lane: replay the stored root
            b <= m_b[k];
            converged <= 1'b1;
            cnt <= pass_count[k];
          end else begin
            converged <= 1'b0;
            a  <= m_a[k];  b  <= m_b[k];  c  <= m_c[k];
            fa <= m_fa[k]; fb <= item.f_new; fc <= m_fc[k];
            tol_act <= 64'sd1 + 64'({1'b0, m_tol[k]} >> 1);
            cnt <= (pass_count[k] == 16'hFFFF) ? 16'hFFFF : pass_count[k] + 16'd1;
          end
        end
        S_PREP: begin
          // keep the root bracketed
          if ((fb > 0 && fc > 0) || (fb < 0 && fc < 0)) begin
            c <= a; fc <= fa;
          end
          prev <= s_sub(b, a);
        end
        S_SWAP: begin
          if (mag(fc) < mag(fb)) begin
            a <= b; b <= c; c <= b;
            fa <= fb; fb <= fc; fc <= fb;
            step <= s_sub(b, c) / 2;
            cb   <= s_sub(b, c);
          end else begin
            step <= s_sub(c, b) / 2;
            cb   <= s_sub(c, b);
          end
        end
        S_TEST: if (mag(step) <= 64'(tol_act) || fb == 64'sd0) converged <= 1'b1;
        S_D1W: if (au_done) q  <= au_res;
        S_D2W: if (au_done) t1 <= au_res;
        S_D3W: if (au_done) t2 <= au_res;
        S_M1W: if (au_done) begin
          if (a == c) begin
            p <= au_res;
            q <= s_sub(ONE_Q, t2);
          end else r1 <= au_res;
        end
        S_M2W: if (au_done) r1 <= au_res;
        S_M3W: if (au_done) r2 <= au_res;
        S_M4W: if (au_done) p  <= au_res;
        S_M5W: if (au_done) r1 <= au_res;
        S_M6W: if (au_done) q  <= au_res;
        S_SIGN: begin
          if (p > 0) q <= s_neg(q);
          else p <= s_neg(p);
        end
        S_L1W: if (au_done) r1 <= au_res;
        S_L2W: if (au_done) lim1 <= au_res;
        S_L3W: if (au_done) r1 <= au_res;
        S_L4W: if (au_done) lim1 <= s_sub(lim1, au_res);
        S_L5W: if (au_done) r2 <= au_res;
        S_L6W: if (au_done) r2 <= au_res;
        S_QW:  if (au_done) step <= au_res;
        S_CLAMP: if (mag(step) < 64'(tol_act)) step <= (step > 0) ? tol_act : -tol_act;
        S_STORE: begin
          pass_count[k] <= cnt;
          if (converged) begin
            lane_done[k] <= 1'b1;
            m_a[k] <= a; m_b[k] <= b; m_c[k] <= c;
            m_fa[k] <= fa; m_fc[k] <= fc;
          end else begin
            m_a[k] <= b; m_fa[k] <= fb;
            m_b[k] <= s_add(b, step); b <= s_add(b, step);
            m_c[k] <= c; m_fc[k] <= fc;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data  <= '{out_lane: item.lane, next_x: b, done_res: converged,
                         passes: cnt};
        end
        default: ;
      endcase
    end
  end

  // assertions
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !au_busy)
    else $error("ready while arithmetic unit busy");
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    au_done |-> !au_busy)
    else $error("arithmetic done while still running");

endmodule
`default_nettype wire
